### rtl/lane_steering_speed_controller_top_defines.svh
// Assertion macros for the lane steering and speed controller.
`ifndef LANE_STEERING_SPEED_CONTROLLER_TOP_DEFINES_SVH
`define LANE_STEERING_SPEED_CONTROLLER_TOP_DEFINES_SVH

// Check a consequence in the same cycle as its cause.
`define LSSC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequence in the cycle after its cause.
`define LSSC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/lssc_pkg.sv
package lssc_pkg;

    // Default width of the lost frame counter
    localparam int LOST_COUNT_WIDTH = 8;
    // Width of the lost frame limit register
    localparam int LOST_LIMIT_W = 8;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_INDEX_W-1:0] REG_ZEBRA_HOLD  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_SPEED = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_SLOW_SPEED  = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_ZEBRA_SPEED = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_JUMP    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_DEAD_BAND   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_LOST_LIMIT  = 3'd6;

    // Register reset values
    localparam logic [7:0]  ZEBRA_HOLD_RST  = 8'd30;
    localparam logic [5:0]  DRIVE_SPEED_RST = 6'd12;
    localparam logic [5:0]  SLOW_SPEED_RST  = 6'd6;
    localparam logic [5:0]  ZEBRA_SPEED_RST = 6'd5;
    localparam logic [15:0] MAX_JUMP_RST    = 16'd10650;
    localparam logic [13:0] DEAD_BAND_RST   = 14'd655;
    localparam logic [7:0]  LOST_LIMIT_RST  = 8'd15;

    // Command codes
    localparam logic [1:0] CMD_FRAME = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_STOP  = 2'd2;

    // Mode codes
    localparam logic [1:0] MODE_LANE  = 2'd0;
    localparam logic [1:0] MODE_LOST  = 2'd1;
    localparam logic [1:0] MODE_ZEBRA = 2'd2;

    // Q2.14 full scale offset
    localparam logic signed [15:0] OFFSET_MAX = 16'sd16384;
    localparam logic [14:0]        RAMP_FULL  = 15'd16384;

    // Steer ramp: 5 + round(75 * num / den), capped at 80
    localparam logic [21:0] RAMP_SPAN2    = 22'd150;
    localparam logic [7:0]  STEER_MIN_MAG = 8'd5;
    localparam logic [7:0]  STEER_MAX_MAG = 8'd80;
    localparam int          QUOT_W        = 7;
    localparam logic [2:0]  DIV_LAST      = 3'd6;

    // EMA weight of the new sample, 0.75 in Q8
    localparam logic signed [17:0] EMA_NEW_Q8 = 18'sd192;

    // Payload words
    typedef struct packed {
        logic [1:0]         command;
        logic               lane_found;
        logic signed [15:0] lane_offset;
        logic               zebra_seen;
    } item_t;

    typedef struct packed {
        logic signed [7:0] steer;
        logic [5:0]        speed;
        logic [1:0]        mode;
        logic              running;
    } result_t;

    // Microcode steps
    localparam int STEP_W = 4;
    localparam logic [STEP_W-1:0] STEP_IDLE   = 4'd0;
    localparam logic [STEP_W-1:0] STEP_CMD    = 4'd1;
    localparam logic [STEP_W-1:0] STEP_ZEBRA  = 4'd2;
    localparam logic [STEP_W-1:0] STEP_GATE   = 4'd3;
    localparam logic [STEP_W-1:0] STEP_RANGE  = 4'd4;
    localparam logic [STEP_W-1:0] STEP_SCALE  = 4'd5;
    localparam logic [STEP_W-1:0] STEP_DIV    = 4'd6;
    localparam logic [STEP_W-1:0] STEP_RAW    = 4'd7;
    localparam logic [STEP_W-1:0] STEP_SMOOTH = 4'd8;
    localparam logic [STEP_W-1:0] STEP_RESULT = 4'd9;
    localparam logic [STEP_W-1:0] STEP_EMIT   = 4'd10;

    // Datapath operations
    localparam logic [3:0] OP_NOP    = 4'd0;
    localparam logic [3:0] OP_LOAD   = 4'd1;
    localparam logic [3:0] OP_CMD    = 4'd2;
    localparam logic [3:0] OP_ZEBRA  = 4'd3;
    localparam logic [3:0] OP_GATE   = 4'd4;
    localparam logic [3:0] OP_RANGE  = 4'd5;
    localparam logic [3:0] OP_SCALE  = 4'd6;
    localparam logic [3:0] OP_DIV    = 4'd7;
    localparam logic [3:0] OP_RAW    = 4'd8;
    localparam logic [3:0] OP_SMOOTH = 4'd9;
    localparam logic [3:0] OP_RESULT = 4'd10;
    localparam logic [3:0] OP_EMIT   = 4'd11;

    // Sequencing conditions
    localparam logic [2:0] COND_NEXT     = 3'd0;
    localparam logic [2:0] COND_WAIT_IN  = 3'd1;
    localparam logic [2:0] COND_CMD      = 3'd2;
    localparam logic [2:0] COND_DEAD     = 3'd3;
    localparam logic [2:0] COND_LOOP     = 3'd4;
    localparam logic [2:0] COND_WAIT_OUT = 3'd5;
    localparam logic [2:0] COND_JUMP     = 3'd6;

    typedef struct packed {
        logic [3:0]        op;
        logic [2:0]        cond;
        logic [STEP_W-1:0] target;
    } ucode_t;

    // Control store: one word per step
    function automatic ucode_t ucode_rom(input logic [STEP_W-1:0] step);
        ucode_t word;
        case (step)
            STEP_IDLE:   word = '{op: OP_LOAD,   cond: COND_WAIT_IN,  target: STEP_IDLE};
            STEP_CMD:    word = '{op: OP_CMD,    cond: COND_CMD,      target: STEP_EMIT};
            STEP_ZEBRA:  word = '{op: OP_ZEBRA,  cond: COND_NEXT,     target: STEP_IDLE};
            STEP_GATE:   word = '{op: OP_GATE,   cond: COND_NEXT,     target: STEP_IDLE};
            STEP_RANGE:  word = '{op: OP_RANGE,  cond: COND_DEAD,     target: STEP_SMOOTH};
            STEP_SCALE:  word = '{op: OP_SCALE,  cond: COND_NEXT,     target: STEP_IDLE};
            STEP_DIV:    word = '{op: OP_DIV,    cond: COND_LOOP,     target: STEP_DIV};
            STEP_RAW:    word = '{op: OP_RAW,    cond: COND_NEXT,     target: STEP_IDLE};
            STEP_SMOOTH: word = '{op: OP_SMOOTH, cond: COND_NEXT,     target: STEP_IDLE};
            STEP_RESULT: word = '{op: OP_RESULT, cond: COND_NEXT,     target: STEP_IDLE};
            STEP_EMIT:   word = '{op: OP_EMIT,   cond: COND_WAIT_OUT, target: STEP_IDLE};
            default:     word = '{op: OP_NOP,    cond: COND_JUMP,     target: STEP_IDLE};
        endcase
        return word;
    endfunction

endpackage

### rtl/lane_steering_speed_controller_top.sv
// Frame word: command, zebra, gate, range, scale, divide, raw, smooth, result and
// emit steps; a deadband offset skips to smooth, a start, stop or unused command
// word goes straight to emit. No new input word is taken until the program is back
// at idle; a frame's length is set by the seven-step restoring divider.
// Reset: registers take their defaults, controller state clears, no result pending.
`include "lane_steering_speed_controller_top_defines.svh"

module lane_steering_speed_controller_top
    import lssc_pkg::*;
#(
    parameter int COUNT_WIDTH = LOST_COUNT_WIDTH
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  item_t                  item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output result_t                result
);

    localparam int CMP_W = (COUNT_WIDTH > LOST_LIMIT_W) ? COUNT_WIDTH : LOST_LIMIT_W;

    // Configuration registers
    logic [7:0]  zebra_hold_reg;
    logic [5:0]  drive_speed_reg;
    logic [5:0]  slow_speed_reg;
    logic [5:0]  zebra_speed_reg;
    logic [15:0] max_jump_reg;
    logic [13:0] dead_band_reg;
    logic [7:0]  lost_limit_reg;

    // Sequencer
    logic [STEP_W-1:0] step_reg, step_next;
    ucode_t            cw;

    // Controller state
    logic [7:0]             zebra_left_reg, zebra_left_next;
    logic signed [15:0]     last_off_reg, last_off_next;
    logic signed [15:0]     smooth_reg, smooth_next;
    logic [COUNT_WIDTH-1:0] lost_count_reg, lost_count_next;
    logic                   run_reg, run_next;

    // Working registers
    logic [1:0]         cmd_reg, cmd_next;
    logic               found_reg, found_next;
    logic signed [15:0] off_reg, off_next;
    logic               zebra_in_reg, zebra_in_next;
    logic [14:0]        num_reg, num_next;
    logic [14:0]        den_reg, den_next;
    logic [21:0]        rem_reg, rem_next;
    logic [21:0]        dsh_reg, dsh_next;
    logic [QUOT_W-1:0]  q_reg, q_next;
    logic [2:0]         div_cnt_reg, div_cnt_next;
    logic signed [7:0]  raw_reg, raw_next;
    logic signed [7:0]  res_steer_reg, res_steer_next;
    logic [5:0]         res_speed_reg, res_speed_next;
    logic [1:0]         res_mode_reg, res_mode_next;

    // Output stage
    result_t result_reg;
    logic    result_valid_reg, result_valid_next;

    // Datapath terms
    logic               item_take;
    logic               slot_free;
    logic               emit_fire;
    logic signed [15:0] off_load;
    logic               zebra_active;
    logic signed [16:0] gate_diff;
    logic [16:0]        diff_mag;
    logic               jump_bad;
    logic [14:0]        abs_off;
    logic [14:0]        db_ext;
    logic               dead;
    logic [14:0]        den_calc;
    logic [14:0]        excess;
    logic               div_take;
    logic [7:0]         mag;
    logic signed [17:0] weighted;
    logic signed [16:0] sm_ext;
    logic [16:0]        sm_mag;
    logic [14:0]        quarter;
    logic signed [17:0] quarter_s;
    logic signed [17:0] ema;
    logic [7:0]         out_mag;
    logic               lost_over;
    logic [5:0]         spd;

    // Fetch the control word of the current step
    assign cw = ucode_rom(step_reg);

    assign item_stall = (cw.op != OP_LOAD);
    assign item_take  = item_valid && !item_stall;
    assign slot_free  = !result_valid_reg || !result_stall;
    assign emit_fire  = (cw.op == OP_EMIT) && slot_free;

    // Saturate the incoming offset to the Q2.14 unit range
    always_comb
    begin
        if (item.lane_offset > OFFSET_MAX)
        begin
            off_load = OFFSET_MAX;
        end
        else if (item.lane_offset < -OFFSET_MAX)
        begin
            off_load = -OFFSET_MAX;
        end
        else
        begin
            off_load = item.lane_offset;
        end
    end

    // Jump gate terms
    assign zebra_active = (zebra_left_reg != 8'd0);
    assign gate_diff    = 17'(off_reg) - 17'(last_off_reg);
    assign diff_mag     = gate_diff[16] ? 17'(-gate_diff) : 17'(gate_diff);
    assign jump_bad     = diff_mag > {1'b0, max_jump_reg};

    // Deadband and ramp terms
    assign abs_off  = off_reg[15] ? 15'(-off_reg) : 15'(off_reg);
    assign db_ext   = {1'b0, dead_band_reg};
    assign dead     = abs_off < db_ext;
    assign den_calc = RAMP_FULL - db_ext;
    assign excess   = abs_off - db_ext;
    assign div_take = rem_reg >= dsh_reg;

    // Smoothing terms, rounded half away from zero
    assign weighted  = 18'(raw_reg) * EMA_NEW_Q8;
    assign sm_ext    = 17'(smooth_reg);
    assign sm_mag    = sm_ext[16] ? 17'(-sm_ext) : 17'(sm_ext);
    assign quarter   = 15'((sm_mag + 17'd2) >> 2);
    assign quarter_s = smooth_reg[15] ? -$signed(18'(quarter)) : $signed(18'(quarter));
    assign ema       = weighted + quarter_s;
    assign out_mag   = 8'((sm_mag + 17'd128) >> 8);
    assign lost_over = CMP_W'(lost_count_reg) > CMP_W'(lost_limit_reg);

    // Execute the operation of the current step
    always_comb
    begin
        step_next       = step_reg;
        zebra_left_next = zebra_left_reg;
        last_off_next   = last_off_reg;
        smooth_next     = smooth_reg;
        lost_count_next = lost_count_reg;
        run_next        = run_reg;
        cmd_next        = cmd_reg;
        found_next      = found_reg;
        off_next        = off_reg;
        zebra_in_next   = zebra_in_reg;
        num_next        = num_reg;
        den_next        = den_reg;
        rem_next        = rem_reg;
        dsh_next        = dsh_reg;
        q_next          = q_reg;
        div_cnt_next    = div_cnt_reg;
        raw_next        = raw_reg;
        res_steer_next  = res_steer_reg;
        res_speed_next  = res_speed_reg;
        res_mode_next   = res_mode_reg;
        mag             = 8'd0;
        spd             = 6'd0;

        case (cw.op)
            OP_LOAD:
            begin
                if (item_take)
                begin
                    cmd_next      = item.command;
                    found_next    = item.lane_found;
                    off_next      = off_load;
                    zebra_in_next = item.zebra_seen;
                end
            end
            OP_CMD:
            begin
                // Start and stop clear the smoothing; the result steer, speed and mode are zero
                if (cmd_reg == CMD_START)
                begin
                    run_next    = 1'b1;
                    smooth_next = '0;
                end
                else if (cmd_reg == CMD_STOP)
                begin
                    run_next    = 1'b0;
                    smooth_next = '0;
                end
                res_steer_next = '0;
                res_speed_next = '0;
                res_mode_next  = MODE_LANE;
            end
            OP_ZEBRA:
            begin
                // Reload the hold on a crossing, else count it down
                if (zebra_in_reg)
                begin
                    zebra_left_next = zebra_hold_reg;
                end
                else if (zebra_left_reg != 8'd0)
                begin
                    zebra_left_next = zebra_left_reg - 8'd1;
                end
            end
            OP_GATE:
            begin
                // Reuse the last offset in zebra mode, else drop large jumps and zero a lost offset
                if (zebra_active)
                begin
                    off_next   = last_off_reg;
                    found_next = 1'b1;
                end
                else if (found_reg)
                begin
                    if (jump_bad)
                    begin
                        found_next = 1'b0;
                        off_next   = '0;
                    end
                    else
                    begin
                        last_off_next = off_reg;
                    end
                end
                else
                begin
                    off_next = '0;
                end
            end
            OP_RANGE:
            begin
                den_next = den_calc;
                num_next = (excess > den_calc) ? den_calc : excess;
                if (dead)
                begin
                    raw_next = '0;
                end
            end
            OP_SCALE:
            begin
                // Dividend 150*num + den over divisor 2*den gives the rounded ramp
                rem_next     = 22'(num_reg) * RAMP_SPAN2 + 22'(den_reg);
                dsh_next     = {den_reg, 7'b0};
                q_next       = '0;
                div_cnt_next = DIV_LAST;
            end
            OP_DIV:
            begin
                if (div_take)
                begin
                    rem_next = rem_reg - dsh_reg;
                end
                q_next       = {q_reg[QUOT_W-2:0], div_take};
                dsh_next     = dsh_reg >> 1;
                div_cnt_next = div_cnt_reg - 3'd1;
            end
            OP_RAW:
            begin
                mag = 8'(q_reg) + STEER_MIN_MAG;
                if (mag > STEER_MAX_MAG)
                begin
                    mag = STEER_MAX_MAG;
                end
                raw_next = (off_reg > 16'sd0) ? $signed(mag) : -$signed(mag);
            end
            OP_SMOOTH:
            begin
                smooth_next = 16'(ema);
                if (found_reg)
                begin
                    lost_count_next = '0;
                end
                else if (lost_count_reg != {COUNT_WIDTH{1'b1}})
                begin
                    lost_count_next = lost_count_reg + COUNT_WIDTH'(1);
                end
            end
            OP_RESULT:
            begin
                res_steer_next = smooth_reg[15] ? -$signed(out_mag) : $signed(out_mag);
                spd = found_reg ? drive_speed_reg : slow_speed_reg;
                // Stop steering and drop the speed after too many lost frames
                if (lost_over)
                begin
                    spd            = '0;
                    res_steer_next = '0;
                    smooth_next    = '0;
                end
                if (zebra_active)
                begin
                    spd = zebra_speed_reg;
                end
                res_speed_next = run_reg ? spd : 6'd0;
                if (zebra_active)
                begin
                    res_mode_next = MODE_ZEBRA;
                end
                else if (found_reg)
                begin
                    res_mode_next = MODE_LANE;
                end
                else
                begin
                    res_mode_next = MODE_LOST;
                end
            end
            default:
            begin
            end
        endcase

        // Sequence to the next step
        case (cw.cond)
            COND_NEXT:     step_next = step_reg + 4'd1;
            COND_WAIT_IN:  step_next = item_take ? step_reg + 4'd1 : step_reg;
            COND_CMD:      step_next = (cmd_reg != CMD_FRAME) ? cw.target : step_reg + 4'd1;
            COND_DEAD:     step_next = dead ? cw.target : step_reg + 4'd1;
            COND_LOOP:     step_next = (div_cnt_reg != 3'd0) ? cw.target : step_reg + 4'd1;
            COND_WAIT_OUT: step_next = slot_free ? cw.target : step_reg;
            COND_JUMP:     step_next = cw.target;
            default:       step_next = STEP_IDLE;
        endcase
    end

    // Hold a word until taken, load a new one when the slot frees
    assign result_valid_next = (result_valid_reg && result_stall) || emit_fire;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zebra_hold_reg  <= ZEBRA_HOLD_RST;
            drive_speed_reg <= DRIVE_SPEED_RST;
            slow_speed_reg  <= SLOW_SPEED_RST;
            zebra_speed_reg <= ZEBRA_SPEED_RST;
            max_jump_reg    <= MAX_JUMP_RST;
            dead_band_reg   <= DEAD_BAND_RST;
            lost_limit_reg  <= LOST_LIMIT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_ZEBRA_HOLD:  zebra_hold_reg  <= cfg_data[7:0];
                REG_DRIVE_SPEED: drive_speed_reg <= cfg_data[5:0];
                REG_SLOW_SPEED:  slow_speed_reg  <= cfg_data[5:0];
                REG_ZEBRA_SPEED: zebra_speed_reg <= cfg_data[5:0];
                REG_MAX_JUMP:    max_jump_reg    <= cfg_data[15:0];
                REG_DEAD_BAND:   dead_band_reg   <= cfg_data[13:0];
                REG_LOST_LIMIT:  lost_limit_reg  <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    // Advance control and controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg         <= STEP_IDLE;
            zebra_left_reg   <= '0;
            last_off_reg     <= '0;
            smooth_reg       <= '0;
            lost_count_reg   <= '0;
            run_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg         <= step_next;
            zebra_left_reg   <= zebra_left_next;
            last_off_reg     <= last_off_next;
            smooth_reg       <= smooth_next;
            lost_count_reg   <= lost_count_next;
            run_reg          <= run_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Update working and payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        found_reg     <= found_next;
        off_reg       <= off_next;
        zebra_in_reg  <= zebra_in_next;
        num_reg       <= num_next;
        den_reg       <= den_next;
        rem_reg       <= rem_next;
        dsh_reg       <= dsh_next;
        q_reg         <= q_next;
        div_cnt_reg   <= div_cnt_next;
        raw_reg       <= raw_next;
        res_steer_reg <= res_steer_next;
        res_speed_reg <= res_speed_next;
        res_mode_reg  <= res_mode_next;
        if (emit_fire)
        begin
            result_reg.steer   <= res_steer_reg;
            result_reg.speed   <= res_speed_reg;
            result_reg.mode    <= res_mode_reg;
            result_reg.running <= run_reg;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // Ramp quotient never exceeds the 75 step span
    `LSSC_ASSERT_NOW(a_ramp_quotient, (cw.op == OP_RAW), (q_reg <= 7'd75), "ramp out of range")

    // Smoothed steer stays within the Q8 image of the steer limits
    `LSSC_ASSERT_NOW(a_smooth_bound, 1'b1, (sm_mag <= 17'd20480), "smoothed steer out of range")

    // An accepted word starts the program at the command step
    `LSSC_ASSERT_NEXT(a_accept_start, item_take, (step_reg == STEP_CMD), "program not started")

    // A found lane clears the lost frame count
    `LSSC_ASSERT_NEXT(a_lost_clear, (cw.op == OP_SMOOTH) && found_reg,
        (lost_count_reg == '0), "lost count not cleared on a found lane")

endmodule
